// ===== design/scl_pkg.sv =====
package scl_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ID_BITS     = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int STATUS_W    = 3;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int GRP         = 8;
    localparam int GRP_W       = 3;
    localparam int NGRP        = (MAX_ENTRIES + GRP - 1) / GRP;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] RES_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] RES_REJECTED   = 3'd1;
    localparam logic [STATUS_W-1:0] RES_DUPLICATE  = 3'd2;
    localparam logic [STATUS_W-1:0] RES_POPPED     = 3'd3;
    localparam logic [STATUS_W-1:0] RES_NONE       = 3'd4;
    localparam logic [STATUS_W-1:0] RES_CLEARED    = 3'd5;
    localparam logic [STATUS_W-1:0] RES_DUMP_ENTRY = 3'd6;
    localparam logic [STATUS_W-1:0] RES_DUMP_EMPTY = 3'd7;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [DATA_W-1:0]  key;
        logic               free;
        logic               expd;
    } entry_t;

    typedef struct packed {
        logic eval;
        logic shift;
        logic set_exp;
        logic dump_rd;
    } cell_ctl_t;

    typedef struct packed {
        logic g;
        logic bnd;
        logic eq;
        logic u;
    } cell_flag_t;

    function automatic logic sorts_ahead(
        input logic [DATA_W-1:0]  da,
        input logic [ID_BITS-1:0] ia,
        input logic               fa,
        input logic [DATA_W-1:0]  db,
        input logic [ID_BITS-1:0] ib,
        input logic               fb
    );
        logic r;
        if (da != db) begin
            r = da < db;
        end else if (ia != ib) begin
            r = ia < ib;
        end else begin
            r = !fa && fb;
        end
        return r;
    endfunction

endpackage

// ===== design/scl_req_if.sv =====
interface scl_req_if;
    logic                         valid;
    logic                         ready;
    scl_pkg::cmd_t                command;
    logic [scl_pkg::DATA_W-1:0]   node_id;
    logic [scl_pkg::DATA_W-1:0]   distance_key;
    logic                         free_flag;

    modport source (output valid, output command, output node_id,
                    output distance_key, output free_flag, input ready);
    modport sink   (input valid, input command, input node_id,
                    input distance_key, input free_flag, output ready);
endinterface

// ===== design/scl_rsp_if.sv =====
interface scl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [scl_pkg::STATUS_W-1:0] status;
    logic [scl_pkg::DATA_W-1:0]   out_point_id;
    logic [scl_pkg::DATA_W-1:0]   out_distance_key;
    logic                         out_free_flag;
    logic [scl_pkg::CNT_W-1:0]    position;
    logic [scl_pkg::CNT_W-1:0]    entry_count;
    logic                         last_of_run;

    modport source (output valid, output status, output out_point_id,
                    output out_distance_key, output out_free_flag, output position,
                    output entry_count, output last_of_run, input ready);
    modport sink   (input valid, input status, input out_point_id,
                    input out_distance_key, input out_free_flag, input position,
                    input entry_count, input last_of_run, output ready);
endinterface

// ===== design/scl_cell.sv =====
module scl_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [scl_pkg::IDX_W-1:0]  idx,
    input  scl_pkg::cell_ctl_t         ctl,
    input  scl_pkg::entry_t            new_entry,
    input  scl_pkg::entry_t            left_entry,
    input  logic                       left_g,
    input  logic [scl_pkg::CNT_W-1:0]  fill,
    input  logic [scl_pkg::CNT_W-1:0]  nu,
    input  logic [scl_pkg::CNT_W-1:0]  dump_idx,
    output scl_pkg::entry_t            entry,
    output scl_pkg::cell_flag_t        flag,
    output scl_pkg::entry_t            rd_entry
);

    scl_pkg::entry_t            entry_reg;
    scl_pkg::entry_t            entry_next;
    logic                       g_reg;
    logic                       eq_reg;
    logic                       u_reg;
    logic                       sel_reg;
    logic [scl_pkg::CNT_W-1:0]  idx_c;
    logic                       valid;
    logic                       lt;
    logic                       eq;
    logic                       bnd;
    logic                       rd_sel;

    always_comb
    begin
        idx_c = scl_pkg::CNT_W'(idx);
        valid = idx_c < fill;
        lt    = scl_pkg::sorts_ahead(new_entry.key, new_entry.id, new_entry.free,
                                     entry_reg.key, entry_reg.id, entry_reg.free);
        eq    = (new_entry.key == entry_reg.key) && (new_entry.id == entry_reg.id)
                && (new_entry.free == entry_reg.free);
        bnd   = g_reg && !left_g;

        entry_next = entry_reg;
        if (ctl.shift && g_reg)
        begin
            if (bnd)
            begin
                entry_next      = new_entry;
                entry_next.expd = 1'b0;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctl.set_exp && sel_reg)
        begin
            entry_next.expd = 1'b1;
        end

        rd_sel   = ctl.dump_rd ? (idx_c == dump_idx) : sel_reg;
        rd_entry = rd_sel ? entry_reg : '0;

        entry    = entry_reg;
        flag.g   = g_reg;
        flag.bnd = bnd;
        flag.eq  = eq_reg;
        flag.u   = u_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg   <= 1'b0;
            eq_reg  <= 1'b0;
            u_reg   <= 1'b0;
            sel_reg <= 1'b0;
        end
        else if (ctl.eval)
        begin
            g_reg   <= !valid || lt;
            eq_reg  <= valid && eq;
            u_reg   <= valid && !entry_reg.expd && (idx_c > nu);
            sel_reg <= idx_c == nu;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/sorted_candidate_list.sv =====
// Sorted candidate list for best-first search, kept as a row of cells that
// each hold one entry in ascending order of distance key, point id and free
// flag. Commands arrive as words on the req channel: insert, pop closest
// unexpanded, clear and dump. Results leave as words on the rsp channel.
// Insert, pop and clear pass through two states: in S_EVAL every cell
// compares the new word against its own entry, in S_COMMIT the row shifts
// or marks in place and the result is loaded into the output register.
// The next command can be taken in S_COMMIT, while the result of the last
// one is loaded. A dump gives one result word per cycle for each stored
// entry while the receiver takes them, after passing through S_EVAL and
// S_COMMIT, and holds the input until its last word is loaded.
// The user writes the capacity register through cfg_we and cfg_wdata only
// while the list is idle; the block does not enforce this. Zero acts as one,
// values over the row length act as it; lowering it cuts the list at once.
// Reset empties the list and sets the capacity to the full row; no clearing
// pass is needed. When the receiver stalls, the output register holds its
// word, one further command may be taken and evaluated, and the block then
// waits with the input held off until the output register frees up.
module sorted_candidate_list (
    input  logic                      clk,
    input  logic                      rst_n,
    scl_req_if.sink                   req,
    scl_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [scl_pkg::CNT_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_DUMP   = 4'b1000
    } fsm_t;

    localparam int N = scl_pkg::MAX_ENTRIES;
    localparam int CW = scl_pkg::CNT_W;

    fsm_t                           state_reg;
    fsm_t                           state_next;
    logic [CW-1:0]                  cap_reg;
    logic [CW-1:0]                  cap_next;
    logic [CW-1:0]                  fill_reg;
    logic [CW-1:0]                  fill_next;
    logic [CW-1:0]                  nu_reg;
    logic [CW-1:0]                  nu_next;
    logic [CW-1:0]                  dump_idx_reg;
    logic [CW-1:0]                  dump_idx_next;

    scl_pkg::cmd_t                  cmd_reg;
    logic [scl_pkg::ID_BITS-1:0]    id_reg;
    logic [scl_pkg::DATA_W-1:0]     key_reg;
    logic                           free_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [scl_pkg::STATUS_W-1:0]   status_reg;
    logic [scl_pkg::STATUS_W-1:0]   status_next;
    logic [scl_pkg::DATA_W-1:0]     opid_reg;
    logic [scl_pkg::DATA_W-1:0]     opid_next;
    logic [scl_pkg::DATA_W-1:0]     okey_reg;
    logic [scl_pkg::DATA_W-1:0]     okey_next;
    logic                           ofree_reg;
    logic                           ofree_next;
    logic [CW-1:0]                  pos_reg;
    logic [CW-1:0]                  pos_next;
    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  cnt_next;
    logic                           last_reg;
    logic                           last_next;

    scl_pkg::entry_t                cell_entry [N];
    scl_pkg::cell_flag_t            cell_flag  [N];
    scl_pkg::entry_t                cell_rd    [N];
    scl_pkg::entry_t                new_entry;
    scl_pkg::cell_ctl_t             ctl;

    logic                           slot_free;
    logic                           accept;
    logic                           commit_go;
    logic                           out_load;
    logic                           any_bnd;
    logic                           any_eq;
    logic [CW-1:0]                  pos_ins;
    logic [CW-1:0]                  pos_dup;
    scl_pkg::entry_t                rd;
    logic [N-1:0]                   u_vec;
    logic [scl_pkg::IDX_W:0]        first_u;
    logic                           full;
    logic                           reject;
    logic                           do_ins;
    logic [CW-1:0]                  nf;
    logic [CW-1:0]                  cap_wr;
    logic                           dump_last;

    function automatic logic [scl_pkg::IDX_W:0] first_set(input logic [N-1:0] v);
        logic [scl_pkg::NGRP-1:0]                   gany;
        logic [scl_pkg::NGRP-1:0][scl_pkg::GRP_W-1:0] glow;
        logic [scl_pkg::IDX_W:0]                    r;
        gany = '0;
        glow = '0;
        r    = '0;
        for (int g = 0; g < scl_pkg::NGRP; g++)
        begin
            for (int k = scl_pkg::GRP - 1; k >= 0; k--)
            begin
                if ((g * scl_pkg::GRP + k) < N)
                begin
                    if (v[g * scl_pkg::GRP + k])
                    begin
                        gany[g] = 1'b1;
                        glow[g] = scl_pkg::GRP_W'(k);
                    end
                end
            end
        end
        for (int g = scl_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (gany[g])
            begin
                r = {1'b1, scl_pkg::IDX_W'(g * scl_pkg::GRP + int'(glow[g]))};
            end
        end
        return r;
    endfunction

    assign new_entry.id   = id_reg;
    assign new_entry.key  = key_reg;
    assign new_entry.free = free_reg;
    assign new_entry.expd = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        scl_pkg::entry_t left_e;
        logic            left_g;
        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_link
            assign left_e = cell_entry[i-1];
            assign left_g = cell_flag[i-1].g;
        end
        scl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (scl_pkg::IDX_W'(i)),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .left_entry (left_e),
            .left_g     (left_g),
            .fill       (fill_reg),
            .nu         (nu_reg),
            .dump_idx   (dump_idx_reg),
            .entry      (cell_entry[i]),
            .flag       (cell_flag[i]),
            .rd_entry   (cell_rd[i])
        );
    end

    always_comb
    begin
        any_bnd = 1'b0;
        any_eq  = 1'b0;
        pos_ins = '0;
        pos_dup = '0;
        rd      = '0;
        for (int i = 0; i < N; i++)
        begin
            if (cell_flag[i].bnd)
            begin
                any_bnd = 1'b1;
                pos_ins = pos_ins | CW'(i);
            end
            if (cell_flag[i].eq)
            begin
                any_eq  = 1'b1;
                pos_dup = pos_dup | CW'(i);
            end
            u_vec[i] = cell_flag[i].u;
            rd       = rd | cell_rd[i];
        end
        first_u = first_set(u_vec);
    end

    always_comb
    begin
        slot_free = !out_valid_reg || rsp.ready;
        full      = fill_reg >= cap_reg;
        reject    = full && !any_eq && (!any_bnd || (pos_ins == fill_reg));
        do_ins    = !reject && !any_eq;
        nf        = full ? cap_reg : CW'(fill_reg + 1'b1);
        dump_last = dump_idx_reg == CW'(fill_reg - 1'b1);

        commit_go = (state_reg == S_COMMIT)
                    && (slot_free || ((cmd_reg == scl_pkg::CMD_DUMP) && (fill_reg != '0)));
        req.ready = (state_reg == S_IDLE)
                    || ((state_reg == S_COMMIT) && slot_free && (cmd_reg != scl_pkg::CMD_DUMP));
        accept    = req.valid && req.ready;

        ctl.eval    = state_reg == S_EVAL;
        ctl.shift   = commit_go && (cmd_reg == scl_pkg::CMD_INSERT) && do_ins;
        ctl.set_exp = commit_go && (cmd_reg == scl_pkg::CMD_POP) && (nu_reg < fill_reg);
        ctl.dump_rd = state_reg == S_DUMP;

        state_next    = state_reg;
        fill_next     = fill_reg;
        nu_next       = nu_reg;
        dump_idx_next = dump_idx_reg;
        out_load      = 1'b0;
        status_next   = status_reg;
        opid_next     = '0;
        okey_next     = '0;
        ofree_next    = 1'b0;
        pos_next      = '0;
        cnt_next      = fill_reg;
        last_next     = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = accept ? S_EVAL : S_IDLE;
                    out_load   = 1'b1;
                    case (cmd_reg)
                        scl_pkg::CMD_INSERT:
                        begin
                            if (reject)
                            begin
                                status_next = scl_pkg::RES_REJECTED;
                            end
                            else if (any_eq)
                            begin
                                status_next = scl_pkg::RES_DUPLICATE;
                                pos_next    = pos_dup;
                            end
                            else
                            begin
                                status_next = scl_pkg::RES_INSERTED;
                                pos_next    = pos_ins;
                                fill_next   = nf;
                                cnt_next    = nf;
                                nu_next     = (pos_ins < nu_reg) ? pos_ins : nu_reg;
                                if (nu_next > nf)
                                begin
                                    nu_next = nf;
                                end
                            end
                        end
                        scl_pkg::CMD_POP:
                        begin
                            if (nu_reg < fill_reg)
                            begin
                                status_next = scl_pkg::RES_POPPED;
                                opid_next   = scl_pkg::DATA_W'(rd.id);
                                okey_next   = rd.key;
                                ofree_next  = rd.free;
                                pos_next    = nu_reg;
                                nu_next     = first_u[scl_pkg::IDX_W]
                                              ? CW'(first_u[scl_pkg::IDX_W-1:0]) : fill_reg;
                            end
                            else
                            begin
                                status_next = scl_pkg::RES_NONE;
                            end
                        end
                        scl_pkg::CMD_CLEAR:
                        begin
                            status_next = scl_pkg::RES_CLEARED;
                            fill_next   = '0;
                            nu_next     = '0;
                            cnt_next    = '0;
                        end
                        scl_pkg::CMD_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = scl_pkg::RES_DUMP_EMPTY;
                            end
                            else
                            begin
                                out_load      = 1'b0;
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = scl_pkg::RES_NONE;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    status_next   = scl_pkg::RES_DUMP_ENTRY;
                    opid_next     = scl_pkg::DATA_W'(rd.id);
                    okey_next     = rd.key;
                    ofree_next    = rd.free;
                    pos_next      = dump_idx_reg;
                    last_next     = dump_last;
                    dump_idx_next = CW'(dump_idx_reg + 1'b1);
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wdata == '0)
        begin
            cap_wr = CW'(1);
        end
        else if (cfg_wdata > CW'(N))
        begin
            cap_wr = CW'(N);
        end
        else
        begin
            cap_wr = cfg_wdata;
        end

        cap_next = cap_reg;
        if (cfg_we)
        begin
            cap_next = cap_wr;
            if (fill_next > cap_wr)
            begin
                fill_next = cap_wr;
            end
            if (nu_next > fill_next)
            begin
                nu_next = fill_next;
            end
        end

        out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CW'(N);
            fill_reg      <= '0;
            nu_reg        <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            fill_reg      <= fill_next;
            nu_reg        <= nu_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.command;
            id_reg   <= req.node_id[scl_pkg::ID_BITS-1:0];
            key_reg  <= req.distance_key;
            free_reg <= req.free_flag;
        end
        if (out_load)
        begin
            status_reg <= status_next;
            opid_reg   <= opid_next;
            okey_reg   <= okey_next;
            ofree_reg  <= ofree_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.out_point_id     = opid_reg;
    assign rsp.out_distance_key = okey_reg;
    assign rsp.out_free_flag    = ofree_reg;
    assign rsp.position         = pos_reg;
    assign rsp.entry_count      = cnt_reg;
    assign rsp.last_of_run      = last_reg;

`ifndef SYNTHESIS
    a_nu_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        nu_reg <= fill_reg)
        else $error("first unexpanded pointer beyond fill");

    a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill count beyond capacity");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EVAL)
        else $error("accepted word not evaluated next cycle");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP && slot_free && dump_last)
        |=> (state_reg == S_IDLE && rsp.valid && rsp.last_of_run))
        else $error("dump did not end with a last word");
`endif

endmodule

// ===== verif/scl_checker.sv =====
module scl_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    scl_req_if                        req,
    scl_rsp_if                        rsp,
    input  logic                      cfg_we,
    input  logic [scl_pkg::CNT_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = scl_pkg::DATA_W;
    localparam int CW = scl_pkg::CNT_W;

    typedef struct packed {
        logic [scl_pkg::ID_BITS-1:0] id;
        logic [DW-1:0]               key;
        logic                        free;
        logic                        expd;
    } candidate_t;

    typedef struct packed {
        logic [scl_pkg::STATUS_W-1:0] status;
        logic [DW-1:0]                id;
        logic [DW-1:0]                key;
        logic                         free;
        logic [CW-1:0]                pos;
        logic [CW-1:0]                count;
        logic                         last;
    } result_word_t;

    localparam candidate_t NO_ENTRY = '0;

    candidate_t   cand_list [scl_pkg::MAX_ENTRIES];
    int unsigned  fill;
    int unsigned  next_open;
    int unsigned  capacity;
    result_word_t expected_words [$];

    function automatic int unsigned effective_capacity();
        int unsigned cap;
        cap = capacity & 32'h7F;
        if (cap < 1)
        begin
            cap = 1;
        end
        if (cap > scl_pkg::MAX_ENTRIES)
        begin
            cap = scl_pkg::MAX_ENTRIES;
        end
        return cap;
    endfunction

    function automatic bit ranks_ahead(candidate_t a, candidate_t b);
        bit r;
        if (a.key != b.key)
        begin
            r = a.key < b.key;
        end
        else if (a.id != b.id)
        begin
            r = a.id < b.id;
        end
        else
        begin
            r = (a.free == 1'b0) && (b.free == 1'b1);
        end
        return r;
    endfunction

    function automatic void queue_word(logic [scl_pkg::STATUS_W-1:0] st, candidate_t c,
                                       int unsigned pos, bit last);
        result_word_t w;
        w.status = st;
        w.id     = DW'(c.id);
        w.key    = c.key;
        w.free   = c.free;
        w.pos    = pos[CW-1:0];
        w.count  = fill[CW-1:0];
        w.last   = last;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void predict_command(scl_pkg::cmd_t op, logic [DW-1:0] id,
                                            logic [DW-1:0] key, logic fr);
        candidate_t  fresh;
        int unsigned cap;
        int unsigned slot;
        int unsigned new_fill;
        int          k;
        fresh.id   = id[scl_pkg::ID_BITS-1:0];
        fresh.key  = key;
        fresh.free = fr;
        fresh.expd = 1'b0;
        cap = effective_capacity();
        case (op)
            scl_pkg::CMD_INSERT:
            begin
                if (fill >= cap && fill > 0 && ranks_ahead(cand_list[fill-1], fresh))
                begin
                    queue_word(scl_pkg::RES_REJECTED, NO_ENTRY, 0, 1'b1);
                end
                else
                begin
                    slot = 0;
                    while (slot < fill && !ranks_ahead(fresh, cand_list[slot]))
                    begin
                        slot++;
                    end
                    if (slot > 0 && cand_list[slot-1].key == fresh.key &&
                        cand_list[slot-1].id == fresh.id && cand_list[slot-1].free == fr)
                    begin
                        queue_word(scl_pkg::RES_DUPLICATE, NO_ENTRY, slot - 1, 1'b1);
                    end
                    else
                    begin
                        new_fill = (fill < cap) ? fill + 1 : cap;
                        for (k = int'(new_fill) - 1; k > int'(slot); k--)
                        begin
                            cand_list[k] = cand_list[k-1];
                        end
                        cand_list[slot] = fresh;
                        fill = new_fill;
                        if (slot < next_open)
                        begin
                            next_open = slot;
                        end
                        if (next_open > fill)
                        begin
                            next_open = fill;
                        end
                        queue_word(scl_pkg::RES_INSERTED, NO_ENTRY, slot, 1'b1);
                    end
                end
            end
            scl_pkg::CMD_POP:
            begin
                if (next_open < fill)
                begin
                    slot = next_open;
                    cand_list[slot].expd = 1'b1;
                    while (next_open < fill && cand_list[next_open].expd)
                    begin
                        next_open++;
                    end
                    queue_word(scl_pkg::RES_POPPED, cand_list[slot], slot, 1'b1);
                end
                else
                begin
                    queue_word(scl_pkg::RES_NONE, NO_ENTRY, 0, 1'b1);
                end
            end
            scl_pkg::CMD_CLEAR:
            begin
                fill = 0;
                next_open = 0;
                queue_word(scl_pkg::RES_CLEARED, NO_ENTRY, 0, 1'b1);
            end
            default:
            begin
                if (fill == 0)
                begin
                    queue_word(scl_pkg::RES_DUMP_EMPTY, NO_ENTRY, 0, 1'b1);
                end
                else
                begin
                    for (k = 0; k < int'(fill); k++)
                    begin
                        queue_word(scl_pkg::RES_DUMP_ENTRY, cand_list[k], unsigned'(k),
                                   (k + 1) == int'(fill));
                    end
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [DW-1:0] want,
                                          logic [DW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        int unsigned  cap;
        if (!rst_n)
        begin
            fill        = 0;
            next_open   = 0;
            capacity    = scl_pkg::MAX_ENTRIES;
            fail_count  = 0;
            expected_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity = 32'(cfg_wdata);
                cap = effective_capacity();
                if (fill > cap)
                begin
                    fill = cap;
                end
                if (next_open > fill)
                begin
                    next_open = fill;
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no expectation: status %0d", rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    compare_field("status", DW'(want.status), DW'(rsp.status));
                    compare_field("out_point_id", want.id, rsp.out_point_id);
                    compare_field("out_distance_key", want.key, rsp.out_distance_key);
                    compare_field("out_free_flag", DW'(want.free), DW'(rsp.out_free_flag));
                    compare_field("position", DW'(want.pos), DW'(rsp.position));
                    compare_field("entry_count", DW'(want.count), DW'(rsp.entry_count));
                    compare_field("last_of_run", DW'(want.last), DW'(rsp.last_of_run));
                end
            end
            if (req.valid && req.ready)
            begin
                predict_command(req.command, req.node_id, req.distance_key, req.free_flag);
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 260;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_PHASE = 2;
    localparam int DW             = scl_pkg::DATA_W;
    localparam int CW             = scl_pkg::CNT_W;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_we;
    logic [CW-1:0] cfg_wdata;
    int            fail_count;
    int            outstanding;

    int burst_left;
    bit gaps_on;
    bit long_hold_pending;
    int sent;
    int idle_cycles;

    scl_req_if req ();
    scl_rsp_if rsp ();

    sorted_candidate_list i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    scl_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic send_word(input scl_pkg::cmd_t op, input logic [DW-1:0] id,
                             input logic [DW-1:0] key, input logic fr);
        if (gaps_on && burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 5)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        req.valid        <= 1'b1;
        req.command      <= op;
        req.node_id      <= id;
        req.distance_key <= key;
        req.free_flag    <= fr;
        sent++;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
    endtask

    task automatic wait_for_drain();
        req.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CW-1:0] value);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [DW-1:0] pick_key(int unsigned pool);
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = $urandom;
            default: v = $urandom_range(0, pool);
        endcase
        return v;
    endfunction

    function automatic logic [CW-1:0] pick_capacity();
        logic [CW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = CW'(scl_pkg::MAX_ENTRIES);
            3:       v = CW'(1);
            4:       v = CW'($urandom_range(1, 127));
            default: v = CW'($urandom_range(2, 8));
        endcase
        return v;
    endfunction

    // Receiver: ready follows a mode chosen per stretch, with one long hold-off on request.
    initial
    begin
        int mode;
        int stretch;
        rsp.ready <= 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 60);
            repeat (stretch)
            begin
                @(posedge clk);
                if (long_hold_pending)
                begin
                    long_hold_pending = 1'b0;
                    rsp.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= 1'($urandom_range(0, 1));
                    default: rsp.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("sorted_candidate_list verification failed");
        $finish;
    end

    initial
    begin
        int            phase;
        int            count;
        int            pick;
        scl_pkg::cmd_t op;
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.command      <= scl_pkg::CMD_INSERT;
        req.node_id      <= '0;
        req.distance_key <= '0;
        req.free_flag    <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        long_hold_pending = 1'b0;
        sent              = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, ordering ties, duplicates and the pointer moving back.
        send_word(scl_pkg::CMD_DUMP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_POP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd10, 32'd1, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd20, 32'd2, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(scl_pkg::CMD_INSERT, 32'd10, 32'd1, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd10, 32'd1, 1'b1);
        send_word(scl_pkg::CMD_POP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_POP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_POP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_DUMP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_CLEAR, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_DUMP, 32'd0, 32'd0, 1'b0);

        // A capacity of zero acts as one: full list, reject, duplicate, replace.
        set_capacity('0);
        send_word(scl_pkg::CMD_INSERT, 32'd5, 32'd5, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd6, 32'd6, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd5, 32'd5, 1'b0);
        send_word(scl_pkg::CMD_INSERT, 32'd4, 32'd4, 1'b1);
        send_word(scl_pkg::CMD_POP, 32'd0, 32'd0, 1'b0);
        send_word(scl_pkg::CMD_POP, 32'd0, 32'd0, 1'b0);

        // Capacity above the row length, then lowered to three.
        set_capacity('1);
        repeat (4)
        begin
            send_word(scl_pkg::CMD_INSERT, pick_key(5), pick_key(7),
                      1'($urandom_range(0, 1)));
        end
        set_capacity(CW'(3));
        send_word(scl_pkg::CMD_DUMP, 32'd0, 32'd0, 1'b0);

        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_capacity(pick_capacity());
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == PRESSURE_PHASE)
            begin
                gaps_on = 1'b0;
                long_hold_pending = 1'b1;
            end
            count = $urandom_range(15, 35);
            repeat (count)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                begin
                    op = scl_pkg::CMD_INSERT;
                end
                else if (pick < 84)
                begin
                    op = scl_pkg::CMD_POP;
                end
                else if (pick < 93)
                begin
                    op = scl_pkg::CMD_DUMP;
                end
                else
                begin
                    op = scl_pkg::CMD_CLEAR;
                end
                send_word(op, pick_key(5), pick_key(7), 1'($urandom_range(0, 1)));
            end
            phase++;
        end

        wait_for_drain();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("sorted_candidate_list verification clean");
        end
        else
        begin
            $display("sorted_candidate_list verification failed");
        end
        $finish;
    end

endmodule

// ===== sorted_candidate_list.f =====
design/scl_pkg.sv
design/scl_req_if.sv
design/scl_rsp_if.sv
design/scl_cell.sv
design/sorted_candidate_list.sv
verif/scl_checker.sv
verif/testbench.sv
